/* rtl/core/ppr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and constants of the polar pose regulator
// Payload structs, the per-cell CORDIC state, angle constants and the
// small arithmetic helpers used by the cells and the back end.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int STAGE_W       = 5;
  // front register, one register per cell, five back-end stages
  localparam int LATENCY       = CORDIC_STAGES + 6;
  localparam int XW            = 36;
  localparam int ZW            = 32;
  localparam int AW            = 34;

  localparam logic signed [AW-1:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [AW-1:0] TWO_PI_Q28  = 34'sd1686629714;
  localparam logic signed [AW-1:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic        [29:0]   INV_K_Q30   = 30'd652032874;

  typedef enum logic [1:0] {
    REG_DIST_GAIN,
    REG_BEAR_GAIN,
    REG_HEAD_GAIN
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [15:0] cur_heading;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] goal_heading;
  } pose_in_t;

  typedef struct packed {
    logic signed [31:0] turn_rate;
    logic signed [31:0] speed;
    logic               backward;
  } cmd_out_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
    logic signed [15:0]   cur_heading;
    logic signed [15:0]   goal_heading;
  } cell_t;

  function automatic logic signed [ZW-1:0] atan_q28(input logic [STAGE_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = 32'sd210828714;
      5'd1: r = 32'sd124459457;
      5'd2: r = 32'sd65760959;
      5'd3: r = 32'sd33381290;
      5'd4: r = 32'sd16755422;
      5'd5: r = 32'sd8385879;
      5'd6: r = 32'sd4193963;
      5'd7: r = 32'sd2097109;
      5'd8: r = 32'sd1048571;
      5'd9: r = 32'sd524287;
      default: begin
        if (i <= 5'd28) r = 32'sd1 <<< (5'd28 - i);
        else            r = '0;
      end
    endcase
    return r;
  endfunction

  // fold once into (-pi, pi]; every caller stays within one turn of the range
  function automatic logic signed [AW-1:0] wrap_pi(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    if (v > PI_Q28)       r = v - TWO_PI_Q28;
    else if (v <= -PI_Q28) r = v + TWO_PI_Q28;
    else                  r = v;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -42'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

/* rtl/core/ppr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_front: offset and quadrant pre-rotation
// Forms the goal offset and turns left half plane vectors by +-pi/2.
// ----------------------------------------------------------------------------
module ppr_front (
  input  logic             clk_i,
  input  logic             en_i,
  input  ppr_pkg::pose_in_t d_i,
  output ppr_pkg::cell_t    q_o
);
  import ppr_pkg::*;

  logic signed [32:0]   dx, dy;
  logic signed [XW-1:0] xe, ye;
  cell_t                c_d, c_q;

  always_comb begin
    dx = 33'(d_i.goal_x) - 33'(d_i.cur_x);
    dy = 33'(d_i.goal_y) - 33'(d_i.cur_y);
    xe = XW'(dx);
    ye = XW'(dy);
    c_d.zero         = (dx == '0) && (dy == '0);
    c_d.cur_heading  = d_i.cur_heading;
    c_d.goal_heading = d_i.goal_heading;
    c_d.x = xe;
    c_d.y = ye;
    c_d.z = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        c_d.x = ye;
        c_d.y = -xe;
        c_d.z = HALF_PI_Q28[ZW-1:0];
      end else begin
        c_d.x = -ye;
        c_d.y = xe;
        c_d.z = -(HALF_PI_Q28[ZW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) c_q <= c_d;
  end

  assign q_o = c_q;

endmodule

/* rtl/core/ppr_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_cell: one CORDIC vectoring micro-rotation
// Rotates toward the x axis by atan(2^-i) and registers the result.
// ----------------------------------------------------------------------------
module ppr_cell (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ppr_pkg::STAGE_W-1:0] stage_i,
  input  ppr_pkg::cell_t              d_i,
  output ppr_pkg::cell_t              q_o
);
  import ppr_pkg::*;

  logic signed [XW-1:0] xs, ys;
  cell_t                c_d, c_q;

  always_comb begin
    xs  = d_i.x >>> stage_i;
    ys  = d_i.y >>> stage_i;
    c_d = d_i;
    if (d_i.y > 0) begin
      c_d.x = d_i.x + ys;
      c_d.y = d_i.y - xs;
      c_d.z = d_i.z + atan_q28(stage_i);
    end else begin
      c_d.x = d_i.x - ys;
      c_d.y = d_i.y + xs;
      c_d.z = d_i.z - atan_q28(stage_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) c_q <= c_d;
  end

  assign q_o = c_q;

endmodule

/* rtl/core/ppr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_back: magnitude scaling, angle wraps and gain stages
// Five registered stages from CORDIC result to the saturated commands.
// ----------------------------------------------------------------------------
module ppr_back (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [14:0]       kp_i,
  input  logic [14:0]       ka_i,
  input  logic signed [15:0] kb_i,
  input  ppr_pkg::cell_t    d_i,
  output ppr_pkg::cmd_out_t q_o
);
  import ppr_pkg::*;

  // stage 1: partial products of x / K, bearing error
  logic signed [AW-1:0] thq1, phi1, a1_w;
  logic [47:0]          plo_d, plo_q;
  logic [46:0]          phi_d, phi_q;
  logic signed [31:0]   a1_d, a1_q;
  logic signed [15:0]   th1_q, gh1_q;

  always_comb begin
    thq1  = {{3{d_i.cur_heading[15]}}, d_i.cur_heading, 15'b0};
    phi1  = d_i.zero ? '0 : AW'(d_i.z);
    a1_w  = wrap_pi(phi1 - thq1);
    a1_d  = a1_w[31:0];
    plo_d = d_i.x[17:0] * INV_K_Q30;
    phi_d = d_i.x[34:18] * INV_K_Q30;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      a1_q  <= a1_d;
      th1_q <= d_i.cur_heading;
      gh1_q <= d_i.goal_heading;
    end
  end

  // stage 2: round the magnitude, first wrap of beta
  logic signed [AW-1:0] thq2, t2_w;
  logic [65:0]          msum;
  logic [33:0]          mag_d, mag_q;
  logic signed [31:0]   t2_d, t2_q, a2_q;
  logic signed [15:0]   gh2_q;

  always_comb begin
    thq2  = {{3{th1_q[15]}}, th1_q, 15'b0};
    t2_w  = wrap_pi(-thq2 - AW'(a1_q));
    t2_d  = t2_w[31:0];
    msum  = {1'b0, phi_q, 18'b0} + 66'(plo_q) + 66'd536870912;
    mag_d = msum[63:30];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      t2_q  <= t2_d;
      a2_q  <= a1_q;
      gh2_q <= gh1_q;
    end
  end

  // stage 3: final wrap of beta, distance gain
  logic signed [AW-1:0] gq3, b3_w;
  logic signed [31:0]   b3_d, b3_q, a3_q;
  logic [48:0]          vp_d, vp_q;

  always_comb begin
    gq3  = {{3{gh2_q[15]}}, gh2_q, 15'b0};
    b3_w = wrap_pi(AW'(t2_q) + gq3);
    b3_d = b3_w[31:0];
    vp_d = kp_i * mag_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b3_q <= b3_d;
      a3_q <= a2_q;
      vp_q <= vp_d;
    end
  end

  // stage 4: angle gains, speed rounding, direction
  logic signed [47:0] pa_d, pa_q, pb_d, pb_q;
  logic [49:0]        vr;
  logic [40:0]        v4_d, v4_q;
  logic               bk_d, bk_q;

  always_comb begin
    pa_d = $signed({1'b0, ka_i}) * a3_q;
    pb_d = kb_i * b3_q;
    vr   = 50'(vp_q) + 50'd128;
    v4_d = vr[48:8];
    bk_d = !((AW'(a3_q) > -HALF_PI_Q28) && (AW'(a3_q) <= HALF_PI_Q28));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      v4_q <= v4_d;
      bk_q <= bk_d;
    end
  end

  // stage 5: sum, sign and clamp into the output register
  logic signed [48:0] wsum;
  logic signed [41:0] wv, vv;
  cmd_out_t           o_d, o_q;

  always_comb begin
    wsum = 49'(pa_q) + 49'(pb_q) + 49'sd524288;
    wv   = 42'(wsum >>> 20);
    vv   = $signed({1'b0, v4_q});
    if (bk_q) begin
      wv = -wv;
      vv = -vv;
    end
    o_d.turn_rate = sat32(wv);
    o_d.speed     = sat32(vv);
    o_d.backward  = bk_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) o_q <= o_d;
  end

  assign q_o = o_q;

endmodule

/* rtl/core/polar_pose_regulator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_pose_regulator: unicycle pose regulator in polar coordinates
// Pipelined CORDIC chain from a pose pair to speed and turn rate commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one current and
//   one goal pose per transfer. Output channel (out_valid_o / out_ready_i /
//   out_data_o) returns one command per input, in order.
//   The pipeline holds one front register, one register per CORDIC cell and
//   five back-end stages. Throughput is one transfer per cycle while the
//   receiver does not stall; the chain of cells sets the depth, not the rate,
//   since every cell hands its vector on in each cycle that it advances.
//   When the receiver stalls with a result pending, the whole pipeline holds
//   and in_ready_o drops; bubbles ride along and cost nothing when unstalled.
//   Reset clears all in-flight valid bits and loads the gains with
//   kp = 1.0, ka = 2.0, kb = -1.0 (Q8.8). Gains are written through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write them only while
//   the block is idle, which the block itself does not enforce; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module polar_pose_regulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ppr_pkg::pose_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ppr_pkg::cmd_out_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import ppr_pkg::*;

  logic                adv;
  logic [LATENCY-1:0]  vld_q;
  logic [14:0]         kp_q, ka_q;
  logic signed [15:0]  kb_q;

  // advance everything whenever the output slot is free or being drained
  assign adv        = !vld_q[LATENCY-1] || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[LATENCY-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LATENCY-2:0], in_valid_i};
    end
  end

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= 15'd256;
      ka_q <= 15'd512;
      kb_q <= -16'sd256;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DIST_GAIN: kp_q <= cfg_wdata_i[14:0];
        REG_BEAR_GAIN: ka_q <= cfg_wdata_i[14:0];
        REG_HEAD_GAIN: kb_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // front, chain of cells, back end
  cell_t chain [CORDIC_STAGES+1];

  ppr_front u_front (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (in_data_i),
    .q_o   (chain[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    ppr_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .stage_i (STAGE_W'(g)),
      .d_i     (chain[g]),
      .q_o     (chain[g+1])
    );
  end

  ppr_back u_back (
    .clk_i (clk_i),
    .en_i  (adv),
    .kp_i  (kp_q),
    .ka_i  (ka_q),
    .kb_i  (kb_q),
    .d_i   (chain[CORDIC_STAGES]),
    .q_o   (out_data_o)
  );

endmodule

/* rtl/core/ppr_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_chk: port-level checks for the polar pose regulator
// Watches the handshake and the sign relation of the commands.
// ----------------------------------------------------------------------------
module ppr_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ppr_pkg::cmd_out_t out_data_o
);

  // a stalled result stays offered with the same payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transfer dropped or changed under stall");

  // input side takes items exactly when the output slot can move
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready disagrees with output slot");

  a_fwd_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.backward |-> !out_data_o.speed[31])
    else $error("forward command with negative speed");

  a_back_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.backward |->
      (out_data_o.speed[31] || out_data_o.speed == '0))
    else $error("backward command with positive speed");

endmodule

bind polar_pose_regulator ppr_chk u_ppr_chk (.*);
